@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property holds at every clock edge out of reset.
`define SFWS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression never true at a clock edge out of reset.
`define SFWS_ASSERT_NEVER(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SFWS_ASSERT(name, clk, rstn, prop, msg)
`define SFWS_ASSERT_NEVER(name, clk, rstn, expr, msg)
`endif
`endif

@@ rtl/core/sfws_pkg.sv @@
// Types, character codes and helpers of the shell first word splitter.
package sfws_pkg;

  localparam int unsigned OffsetBitsDefault = 16;
  localparam int unsigned RestOffsetWidth   = 16;
  localparam int unsigned QueueDepth        = 4;

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDq     = 8'h22;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChSq     = 8'h27;
  localparam logic [7:0] ChBs     = 8'h5C;
  localparam logic [7:0] ChBtick  = 8'h60;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_WORD,
    PH_SQ,
    PH_DQ,
    PH_DQ_BS,
    PH_BS,
    PH_TRAIL,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_REST = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [7:0]                 word_byte;
    logic [RestOffsetWidth-1:0] rest_offset;
    logic                       last;
  } result_t;

  // Up to two results from one byte, first one in r0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNl);
  endfunction

  function automatic logic dq_escapable(logic [7:0] c);
    return (c == ChDq) || (c == ChBs) || (c == ChBtick) || (c == ChDollar) || (c == ChNl);
  endfunction

  function automatic result_t mk_res(kind_e k, logic [7:0] b,
                                     logic [RestOffsetWidth-1:0] off);
    result_t r;
    r.kind        = k;
    r.word_byte   = (k == KIND_BYTE) ? b : 8'h00;
    r.rest_offset = (k == KIND_REST) ? off : '0;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/sfws_parse.sv @@
// Quote/escape state machine: decodes one byte per step into up to two results.
`include "assert_macros.svh"
module sfws_parse #(
  parameter int unsigned OffsetBits = sfws_pkg::OffsetBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output sfws_pkg::res_pair_t   res_o
);
  import sfws_pkg::*;

  phase_e                phase_q, phase_d;
  logic                  found_q, found_d;
  logic [OffsetBits-1:0] idx_q, idx_d;

  logic [31:0]                idx_ext;
  logic [RestOffsetWidth-1:0] off;
  res_pair_t                  res;

  // Rest offset clipped to the port width
  assign idx_ext = 32'(idx_q);
  assign off = (idx_ext > 32'(16'hFFFF)) ? 16'hFFFF : idx_ext[RestOffsetWidth-1:0];

  // Decode and next state
  always_comb begin
    phase_e ph;
    logic   wf;
    ph      = phase_q;
    wf      = found_q;
    res     = '0;
    if (ph == PH_SKIP) begin
      if (byte_i == ChNul) begin
        res.r0  = mk_res(KIND_FAIL, 8'h00, off);
        res.cnt = 2'd1;
      end else if (!is_blank(byte_i)) begin
        ph = PH_WORD;
      end
    end
    case (ph)
      PH_WORD: begin
        if (byte_i == ChNul) begin
          res.r0  = wf ? mk_res(KIND_REST, 8'h00, off) : mk_res(KIND_FAIL, 8'h00, off);
          res.cnt = 2'd1;
        end else if (is_blank(byte_i)) begin
          if (wf) begin
            ph = PH_TRAIL;
          end else begin
            // only escaped newlines so far: no word
            res.r0  = mk_res(KIND_FAIL, 8'h00, off);
            res.cnt = 2'd1;
            ph      = PH_DONE;
          end
        end else if (byte_i == ChSq) begin
          ph = PH_SQ;
          wf = 1'b1;
        end else if (byte_i == ChDq) begin
          ph = PH_DQ;
          wf = 1'b1;
        end else if (byte_i == ChBs) begin
          ph = PH_BS;
        end else begin
          res.r0  = mk_res(KIND_BYTE, byte_i, off);
          res.cnt = 2'd1;
          wf      = 1'b1;
        end
      end
      PH_BS: begin
        if (byte_i == ChNul) begin
          res.r0  = mk_res(KIND_FAIL, 8'h00, off);
          res.cnt = 2'd1;
        end else begin
          if (byte_i != ChNl) begin
            res.r0  = mk_res(KIND_BYTE, byte_i, off);
            res.cnt = 2'd1;
            wf      = 1'b1;
          end
          ph = PH_WORD;
        end
      end
      PH_SQ: begin
        if (byte_i == ChNul) begin
          res.r0  = mk_res(KIND_FAIL, 8'h00, off);
          res.cnt = 2'd1;
        end else if (byte_i == ChSq) begin
          ph = PH_WORD;
        end else begin
          res.r0  = mk_res(KIND_BYTE, byte_i, off);
          res.cnt = 2'd1;
        end
      end
      PH_DQ: begin
        if (byte_i == ChNul) begin
          res.r0  = mk_res(KIND_FAIL, 8'h00, off);
          res.cnt = 2'd1;
        end else if (byte_i == ChDq) begin
          ph = PH_WORD;
        end else if (byte_i == ChBs) begin
          ph = PH_DQ_BS;
        end else begin
          res.r0  = mk_res(KIND_BYTE, byte_i, off);
          res.cnt = 2'd1;
        end
      end
      PH_DQ_BS: begin
        if (byte_i == ChNul) begin
          // dangling backslash is still emitted before the failure
          res.r0  = mk_res(KIND_BYTE, ChBs, off);
          res.r1  = mk_res(KIND_FAIL, 8'h00, off);
          res.cnt = 2'd2;
        end else if (dq_escapable(byte_i)) begin
          if (byte_i != ChNl) begin
            res.r0  = mk_res(KIND_BYTE, byte_i, off);
            res.cnt = 2'd1;
          end
          ph = PH_DQ;
        end else begin
          res.r0  = mk_res(KIND_BYTE, ChBs, off);
          res.r1  = mk_res(KIND_BYTE, byte_i, off);
          res.cnt = 2'd2;
          ph      = PH_DQ;
        end
      end
      PH_TRAIL: begin
        if (!is_blank(byte_i)) begin
          res.r0  = mk_res(KIND_REST, 8'h00, off);
          res.cnt = 2'd1;
          ph      = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    // mark the final result of this byte
    if (res.cnt == 2'd1) begin
      res.r0.last = 1'b1;
    end else if (res.cnt == 2'd2) begin
      res.r1.last = 1'b1;
    end

    phase_d = phase_q;
    found_d = found_q;
    idx_d   = idx_q;
    if (step_i) begin
      if (byte_i == ChNul) begin
        phase_d = PH_SKIP;
        found_d = 1'b0;
        idx_d   = '0;
      end else begin
        phase_d = ph;
        found_d = wf;
        if (idx_q != '1) begin
          idx_d = idx_q + OffsetBits'(1);
        end
      end
    end
  end

  assign res_o = res;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  `SFWS_ASSERT(a_term_resets, clk_i, rst_ni, step_i && byte_i == ChNul |=> phase_q == PH_SKIP && idx_q == '0 && !found_q, "terminator did not reset parser")
  `SFWS_ASSERT(a_two_only_dqbs, clk_i, rst_ni, res.cnt == 2'd2 |-> phase_q == PH_DQ_BS, "two results outside escape in double quotes")
  `SFWS_ASSERT(a_done_quiet, clk_i, rst_ni, phase_q == PH_DONE && byte_i != ChNul |-> res.cnt == 2'd0, "result after rest point")

endmodule

@@ rtl/core/sfws_out_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one.
`include "assert_macros.svh"
module sfws_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfws_pkg::res_pair_t push_data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output sfws_pkg::result_t   data_o
);
  import sfws_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  result_t           mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        n_push;
  logic              pop;
  logic [PtrW-1:0]   wr_nxt;

  assign n_push  = push_i ? push_data_i.cnt : 2'd0;
  assign pop     = valid_o && ready_i;
  assign wr_nxt  = wr_q + PtrW'(1);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  // room for the worst case of two results
  assign space_o = (cnt_q <= CntW'(QueueDepth - 2));

  // Pointer and fill count
  always_comb begin
    wr_d  = wr_q + PtrW'(n_push);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= push_data_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_nxt] <= push_data_i.r1;
    end
  end

  `SFWS_ASSERT_NEVER(a_cnt_ovf, clk_i, rst_ni, cnt_q > CntW'(QueueDepth), "result queue overflow")
  `SFWS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, n_push != 2'd0 && !space_o, "push without room")

endmodule

@@ rtl/core/shell_first_word_splitter.sv @@
// Top level of the shell first word splitter.
// Accepts one byte of command text per cycle (byte 0 ends the text) and returns
// the unquoted bytes of the first shell word (tuser 0), then either the rest
// offset (tuser 1) or a failure (tuser 2); tlast marks the final result of a
// byte. A byte goes through an input register and the quote/escape decoder
// into a four-entry result queue, so its first result is presented on the
// output once it has been written into the queue. The sustained rate is one
// byte per cycle; a byte that yields two results (a backslash inside double
// quotes before an ordinary character or the terminator) leaves the queue as
// two separate results, and input stalls while the queue
// holds more than two results. Bytes after the rest point or a failure give no
// results until the terminator, which returns the block to its reset state.
// The internal byte counter is OffsetBits wide and saturates; offsets above
// 65535 read as 65535.
module shell_first_word_splitter #(
  parameter int unsigned OffsetBits = sfws_pkg::OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] word_byte, [23:8] rest_offset
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o
);
  import sfws_pkg::*;

  logic      in_valid_q;
  logic      in_valid_d;
  logic [7:0] in_byte_q;
  logic      space;
  logic      adv;
  res_pair_t res;
  result_t   head;

  // Input register
  assign adv             = in_valid_q && space;
  assign s_axis_tready_o = !in_valid_q || space;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Decoder
  sfws_parse #(
    .OffsetBits(OffsetBits)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  // Result queue
  sfws_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (adv),
    .push_data_i(res),
    .space_o    (space),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .data_o     (head)
  );

  assign m_axis_tdata_o = {head.rest_offset, head.word_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

  `SFWS_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_q && !space |=> in_valid_q && $stable(in_byte_q), "held input byte lost")

endmodule

@@ tb/shell_first_word_splitter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the shell first word splitter: directed texts, stalls, random texts.
module shell_first_word_splitter_tb;
  import sfws_pkg::*;

  localparam logic [15:0] PosMax      = 16'hFFFF;
  localparam int unsigned RandomItems = 1400;
  localparam int unsigned LongBlanks  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePercent = 14;
  localparam int unsigned MaxReports  = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        m_valid;
  logic        m_ready;
  logic [23:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  // Splitter state as predicted
  phase_e      parse_ph;
  logic        word_seen;
  logic [15:0] text_pos;

  result_t     expected_q [$];
  result_t     head_exp;
  int          mismatches;
  int          sent_items;
  bit          src_calm;
  bit          sink_calm;
  int          sink_hold;

  shell_first_word_splitter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNl);
  endfunction

  // Bytes a backslash escapes inside double quotes
  function automatic logic dq_special(logic [7:0] c);
    return (c == ChDq) || (c == ChBs) || (c == ChBtick) || (c == ChDollar) || (c == ChNl);
  endfunction

  function automatic void expect_result(kind_e k, logic [7:0] b, logic [15:0] off);
    result_t r;
    r.kind        = k;
    r.word_byte   = (k == KIND_BYTE) ? b : 8'h00;
    r.rest_offset = (k == KIND_REST) ? off : 16'h0000;
    r.last        = 1'b0;
    expected_q.push_back(r);
  endfunction

  // Advance the predicted parser by one accepted text byte
  function automatic void decode_byte(logic [7:0] c);
    int      n_before;
    result_t tail;
    n_before = expected_q.size();
    if (parse_ph == PH_SKIP) begin
      if (c == ChNul) expect_result(KIND_FAIL, 8'h00, 16'h0000);
      else if (!is_ws(c)) parse_ph = PH_WORD;
    end
    case (parse_ph)
      PH_WORD: begin
        if (c == ChNul) begin
          if (word_seen) expect_result(KIND_REST, 8'h00, text_pos);
          else expect_result(KIND_FAIL, 8'h00, 16'h0000);
        end else if (is_ws(c)) begin
          if (word_seen) begin
            parse_ph = PH_TRAIL;
          end else begin
            expect_result(KIND_FAIL, 8'h00, 16'h0000);
            parse_ph = PH_DONE;
          end
        end else if (c == ChSq) begin
          parse_ph  = PH_SQ;
          word_seen = 1'b1;
        end else if (c == ChDq) begin
          parse_ph  = PH_DQ;
          word_seen = 1'b1;
        end else if (c == ChBs) begin
          parse_ph = PH_BS;
        end else begin
          expect_result(KIND_BYTE, c, 16'h0000);
          word_seen = 1'b1;
        end
      end
      PH_BS: begin
        if (c == ChNul) begin
          expect_result(KIND_FAIL, 8'h00, 16'h0000);
        end else begin
          // backslash-newline vanishes
          if (c != ChNl) begin
            expect_result(KIND_BYTE, c, 16'h0000);
            word_seen = 1'b1;
          end
          parse_ph = PH_WORD;
        end
      end
      PH_SQ: begin
        if (c == ChNul) expect_result(KIND_FAIL, 8'h00, 16'h0000);
        else if (c == ChSq) parse_ph = PH_WORD;
        else expect_result(KIND_BYTE, c, 16'h0000);
      end
      PH_DQ: begin
        if (c == ChNul) expect_result(KIND_FAIL, 8'h00, 16'h0000);
        else if (c == ChDq) parse_ph = PH_WORD;
        else if (c == ChBs) parse_ph = PH_DQ_BS;
        else expect_result(KIND_BYTE, c, 16'h0000);
      end
      PH_DQ_BS: begin
        if (c == ChNul) begin
          expect_result(KIND_BYTE, ChBs, 16'h0000);
          expect_result(KIND_FAIL, 8'h00, 16'h0000);
        end else if (dq_special(c)) begin
          if (c != ChNl) expect_result(KIND_BYTE, c, 16'h0000);
        end else begin
          // backslash kept with an ordinary byte
          expect_result(KIND_BYTE, ChBs, 16'h0000);
          expect_result(KIND_BYTE, c, 16'h0000);
        end
        if (c != ChNul) parse_ph = PH_DQ;
      end
      PH_TRAIL: begin
        if (!is_ws(c)) begin
          expect_result(KIND_REST, 8'h00, text_pos);
          parse_ph = PH_DONE;
        end
      end
      default: ;
    endcase
    // mark the final result of this byte
    if (expected_q.size() > n_before) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
    if (c == ChNul) begin
      parse_ph  = PH_SKIP;
      word_seen = 1'b0;
      text_pos  = '0;
    end else if (text_pos != PosMax) begin
      text_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: kind=%0d byte=%02h offset=%0d last=%0b",
                   m_user, m_data[7:0], m_data[23:8], m_last);
      end else begin
        head_exp = expected_q.pop_front();
        if (m_user !== head_exp.kind || m_data[7:0] !== head_exp.word_byte ||
            m_data[23:8] !== head_exp.rest_offset || m_last !== head_exp.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: exp kind=%0d byte=%02h offset=%0d last=%0b, got kind=%0d byte=%02h offset=%0d last=%0b",
                     head_exp.kind, head_exp.word_byte, head_exp.rest_offset, head_exp.last,
                     m_user, m_data[7:0], m_data[23:8], m_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random idling, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    m_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        m_ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < IdlePercent) begin
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte and wait for its transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!src_calm && $urandom_range(0, 99) < IdlePercent) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    decode_byte(b);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering until every expected result has come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 2))
      0:       return ChSpace;
      1:       return ChTab;
      default: return ChNl;
    endcase
  endfunction

  // Nonzero byte, biased toward the characters the parser cares about
  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(0, 15))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChNl;
      3:       return ChSq;
      4:       return ChDq;
      5:       return ChBs;
      6:       return ChDollar;
      7:       return ChBtick;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Nonzero byte that is neither blank nor quoting
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (is_ws(c) || c == ChSq || c == ChDq || c == ChBs) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // One text built of word segments; a broken text stops inside a segment
  task automatic send_word_text(input bit broken);
    int         segs;
    int         cut;
    int         seg_kind;
    logic [7:0] c;
    repeat ($urandom_range(0, 3)) send_byte(ws_byte());
    segs = $urandom_range(1, 5);
    cut  = broken ? $urandom_range(1, segs) : 0;
    for (int k = 1; k <= segs; k++) begin
      seg_kind = (k == cut) ? $urandom_range(1, 3) : $urandom_range(0, 4);
      case (seg_kind)
        0: repeat ($urandom_range(1, 4)) send_byte(plain_byte());
        1: begin
          // single-quoted run
          send_byte(ChSq);
          repeat ($urandom_range(0, 4)) begin
            c = rand_text_byte();
            if (c == ChSq) c = ChDq;
            send_byte(c);
          end
          if (k != cut) send_byte(ChSq);
        end
        2: begin
          // double-quoted run with escapes
          send_byte(ChDq);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              send_byte(ChBs);
              send_byte(rand_text_byte());
            end else begin
              c = rand_text_byte();
              if (c == ChDq) c = ChSq;
              if (c == ChBs) c = ChBtick;
              send_byte(c);
            end
          end
          if (k == cut && $urandom_range(0, 1) == 0) send_byte(ChBs);
          if (k != cut) send_byte(ChDq);
        end
        3: begin
          send_byte(ChBs);
          if (k != cut) send_byte(rand_text_byte());
        end
        default: begin
          send_byte(ChBs);
          send_byte(ChNl);
        end
      endcase
      if (k == cut) begin
        send_byte(ChNul);
        return;
      end
    end
    // separator and rest of the text
    case ($urandom_range(0, 2))
      0: ;
      1: repeat ($urandom_range(1, 3)) send_byte(ws_byte());
      default: begin
        repeat ($urandom_range(1, 3)) send_byte(ws_byte());
        repeat ($urandom_range(1, 6)) send_byte(rand_text_byte());
      end
    endcase
    send_byte(ChNul);
  endtask

  task automatic send_random_text();
    int style;
    style = $urandom_range(0, 99);
    if (style < 12) begin
      // noise
      repeat ($urandom_range(0, 12)) send_byte(rand_text_byte());
      send_byte(ChNul);
    end else begin
      send_word_text(style < 22);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // terminator while skipping blanks
    send_byte(ChNul);
    // word of backslash-newline only, then bytes ignored after the failure
    send_text(" \\\n x");
    send_byte(ChNul);
    // quoting mix, extreme byte values, word ended by the terminator
    send_byte(8'h01);
    send_text("'\"'\"\\$\\q\\\n\"\\\n");
    send_byte(8'hFF);
    send_byte(ChNul);
    // backslash then terminator inside double quotes
    send_text("\"\\");
    send_byte(ChNul);
    // backslash then terminator outside quotes
    send_text("\\");
    send_byte(ChNul);
    // bytes after the rest point are ignored
    send_text("a b c");
    send_byte(ChNul);
    wait_drained();
  endtask

  task automatic test_output_stall();
    sink_hold = 300;
    src_calm  = 1'b1;
    repeat (40) send_byte(plain_byte());
    send_text(" rest");
    send_byte(ChNul);
    src_calm = 1'b0;
    wait_drained();
  endtask

  // Back-to-back bytes on both sides with a rest offset past eight bits
  task automatic test_long_offset();
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    send_byte(8'h61);
    repeat (LongBlanks) send_byte(ChSpace);
    send_byte(8'h62);
    send_byte(ChNul);
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_texts();
    int start;
    start = sent_items;
    while (sent_items - start < RandomItems) send_random_text();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    s_valid    = 1'b0;
    s_data     = 8'h00;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;
    sink_hold  = 0;
    mismatches = 0;
    sent_items = 0;
    parse_ph   = PH_SKIP;
    word_seen  = 1'b0;
    text_pos   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_output_stall();
    test_long_offset();
    test_random_texts();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("shell_first_word_splitter_tb: PASS");
    end else begin
      $display("shell_first_word_splitter_tb: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("shell_first_word_splitter_tb: FAIL");
    $finish;
  end

endmodule
